/* hw/rtl/rlse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlse_pkg
// Types, codes and the pair-to-symbol table shared by the LED line encoder.
// ----------------------------------------------------------------------------
package rlse_pkg;

   localparam int RESET_BYTES_DEF = 35;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int SYMBOLS_PER_FRAME = 12;

   localparam logic [7:0] FADE_TOP_RST   = 8'd254;
   localparam logic [7:0] FADE_FLOOR_RST = 8'd33;

   localparam logic [7:0] MODE_OFF    = 8'd0;
   localparam logic [7:0] MODE_BREATH = 8'd1;

   typedef enum logic [1:0] {
      CMD_SET_COLOR = 2'd0,
      CMD_TICK      = 2'd1,
      CMD_MODE      = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      BREATH_OFF  = 2'd0,
      BREATH_RISE = 2'd1,
      BREATH_FALL = 2'd2
   } breath_type;

   typedef enum logic {
      CSR_FADE_TOP   = 1'b0,
      CSR_FADE_FLOOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] mode_sel;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       frame_end;
      logic       status;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       status;
   } frame_job_type;

   function automatic logic [7:0] pair_symbol(input logic [1:0] pair);
      logic [7:0] sym;
      case (pair)
         2'd0:    sym = 8'h88;
         2'd1:    sym = 8'h8C;
         2'd2:    sym = 8'hC8;
         default: sym = 8'hCC;
      endcase
      return sym;
   endfunction

endpackage

/* hw/rtl/rlse_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlse_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rlse_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/rlse_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlse_front
// Accept and classify requests, keep breathing state, issue frame jobs.
// ----------------------------------------------------------------------------
module rlse_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  rlse_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wr_data,
   rlse_chan_if.sink              req_chan,
   rlse_chan_if.source            job_chan
);
   import rlse_pkg::*;

   logic [7:0]    fade_top_ff, fade_top_in;
   logic [7:0]    fade_floor_ff, fade_floor_in;
   breath_type    breath_ff, breath_in;
   logic [7:0]    level_ff, level_in;
   logic          take;
   logic          has_frame;
   frame_job_type job;

   assign req_chan.ready   = job_chan.ready;
   assign take             = req_chan.valid && req_chan.ready;
   assign job_chan.valid   = take && has_frame;
   assign job_chan.payload = job;

   always_comb begin
      fade_top_in   = fade_top_ff;
      fade_floor_in = fade_floor_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FADE_TOP:   fade_top_in   = csr_wr_data;
            CSR_FADE_FLOOR: fade_floor_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      breath_in = breath_ff;
      level_in  = level_ff;
      has_frame = 1'b0;
      job       = '0;
      case (req_chan.payload.command)
         CMD_SET_COLOR: begin
            has_frame = 1'b1;
            job.green = req_chan.payload.green;
            job.red   = req_chan.payload.red;
            job.blue  = req_chan.payload.blue;
         end
         CMD_TICK: begin
            unique case (breath_ff)
               BREATH_RISE: begin
                  if (level_ff == fade_top_ff) breath_in = BREATH_FALL;
                  level_in  = level_ff + 8'd1;
                  has_frame = 1'b1;
               end
               BREATH_FALL: begin
                  if (level_ff < fade_floor_ff) breath_in = BREATH_RISE;
                  level_in  = level_ff - 8'd1;
                  has_frame = 1'b1;
               end
               default: ;
            endcase
            job.blue = level_in;
         end
         CMD_MODE: begin
            has_frame = 1'b1;
            if (req_chan.payload.mode_sel == MODE_OFF) begin
               breath_in = BREATH_OFF;
            end else if (req_chan.payload.mode_sel == MODE_BREATH) begin
               breath_in = BREATH_RISE;
               level_in  = 8'd0;
            end else begin
               job.status = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_top_ff   <= FADE_TOP_RST;
         fade_floor_ff <= FADE_FLOOR_RST;
         breath_ff     <= BREATH_OFF;
         level_ff      <= 8'd0;
      end else begin
         fade_top_ff   <= fade_top_in;
         fade_floor_ff <= fade_floor_in;
         if (take) begin
            breath_ff <= breath_in;
            level_ff  <= level_in;
         end
      end
   end

endmodule

/* hw/rtl/rlse_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlse_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module rlse_queue #(
   parameter int DEPTH = rlse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rlse_chan_if.sink   in_chan,
   rlse_chan_if.source out_chan
);
   import rlse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign in_chan.ready    = (count_ff != CNT_W'(DEPTH));
   assign out_chan.valid   = (count_ff != '0);
   assign out_chan.payload = entry_ff[rd_ptr_ff];
   assign push             = in_chan.valid && in_chan.ready;
   assign pop              = out_chan.valid && out_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_chan.payload;
   end

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

/* hw/rtl/rlse_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlse_back
// Serialize a frame job into reset bytes and twelve symbol bytes.
// ----------------------------------------------------------------------------
module rlse_back #(
   parameter int RESET_BYTES = rlse_pkg::RESET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rlse_chan_if.sink   job_chan,
   rlse_chan_if.source rsp_chan
);
   import rlse_pkg::*;

   localparam int FRAME_LEN = RESET_BYTES + SYMBOLS_PER_FRAME;
   localparam int CNT_W     = $clog2(FRAME_LEN);

   frame_job_type    job_ff;
   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             adv, last, take;
   logic [3:0]       sym_idx;
   logic [7:0]       chan_byte;
   logic [1:0]       pair;

   assign adv  = busy_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign last = (cnt_ff == CNT_W'(FRAME_LEN - 1));
   assign take = job_chan.valid && (!busy_ff || (adv && last));

   assign job_chan.ready   = !busy_ff || (adv && last);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      sym_idx = 4'(cnt_ff - CNT_W'(RESET_BYTES));
      case (sym_idx[3:2])
         2'd0:    chan_byte = job_ff.green;
         2'd1:    chan_byte = job_ff.red;
         default: chan_byte = job_ff.blue;
      endcase
      case (sym_idx[1:0])
         2'd0:    pair = chan_byte[7:6];
         2'd1:    pair = chan_byte[5:4];
         2'd2:    pair = chan_byte[3:2];
         default: pair = chan_byte[1:0];
      endcase
      rsp_in.line_byte = (cnt_ff < CNT_W'(RESET_BYTES)) ? 8'h00 : pair_symbol(pair);
      rsp_in.frame_end = last;
      rsp_in.status    = job_ff.status;
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (adv) begin
         rsp_valid_in = 1'b1;
         cnt_in       = cnt_ff + 1'b1;
         if (last) busy_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) job_ff <= job_chan.payload;
      if (adv)  rsp_ff <= rsp_in;
   end

   a_cnt_in_frame: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CNT_W'(FRAME_LEN - 1))
      else $error("byte counter ran past the frame");

   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      (adv && last) |=> rsp_valid_ff && rsp_ff.frame_end)
      else $error("last byte not flagged as frame end");

   a_take_only_free: assert property (@(posedge clock) disable iff (reset)
      take |-> !busy_ff || (adv && last))
      else $error("job taken while a frame is in flight");

endmodule

/* hw/rtl/rgb_led_spi_encoder_with_breathing_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_spi_encoder_with_breathing_unit
// Addressable RGB LED line encoder with blue breathing.
//
//   port group  | dir | contents
//   ------------+-----+-------------------------------------------------
//   req_chan    | in  | command, red, green, blue, mode_sel
//   rsp_chan    | out | line_byte, frame_end, status
//   csr_*       | in  | fade_top (index 0), fade_floor (index 1)
//
// One line byte per cycle while rsp_chan is ready; a frame is RESET_BYTES + 12 bytes (47 by default).
// The front takes a request per cycle while the job queue has room; the back
// serializer sets the sustained rate, taking the next job only as a frame's last byte goes out.
// A tick with breathing off or command 3 produces no bytes.
// Synchronous reset clears breathing state, loads register defaults.
// A stall on rsp_chan holds the byte counter; the queue absorbs requests.
// ----------------------------------------------------------------------------
module rgb_led_spi_encoder_with_breathing_unit #(
   parameter int RESET_BYTES = rlse_pkg::RESET_BYTES_DEF,
   parameter int QUEUE_DEPTH = rlse_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  rlse_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wr_data,
   rlse_chan_if.sink               req_chan,
   rlse_chan_if.source             rsp_chan
);
   import rlse_pkg::*;

   rlse_chan_if #(.payload_type(frame_job_type)) front_job ();
   rlse_chan_if #(.payload_type(frame_job_type)) back_job ();

   rlse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .job_chan    (front_job)
   );

   rlse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_chan  (front_job),
      .out_chan (back_job)
   );

   rlse_back #(.RESET_BYTES(RESET_BYTES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_chan (back_job),
      .rsp_chan (rsp_chan)
   );

endmodule

/* tb/tb_rgb_led_spi_encoder_with_breathing_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_spi_encoder_with_breathing_unit
// Self-checking bench for the LED line encoder: random bursts of set-colour,
// tick and mode requests against a local frame predictor, with fade register
// changes between phases and random back-pressure on the line byte output.
// ----------------------------------------------------------------------------
module tb_rgb_led_spi_encoder_with_breathing_unit;
   import rlse_pkg::*;

   localparam int LEAD_ZEROS    = RESET_BYTES_DEF;
   localparam int FRAME_LEN     = RESET_BYTES_DEF + SYMBOLS_PER_FRAME;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 400;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [7:0]          csr_wr_data;

   rlse_chan_if #(.payload_type(req_payload_type)) req_if ();
   rlse_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   rgb_led_spi_encoder_with_breathing_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if)
   );

   req_payload_type pending_reqs[$];
   rsp_payload_type line_bytes_due[$];

   breath_type breath_now   = BREATH_OFF;
   logic [7:0] blue_lvl     = 8'd0;
   logic [7:0] fade_top_q   = FADE_TOP_RST;
   logic [7:0] fade_floor_q = FADE_FLOOR_RST;

   int mismatch_cnt = 0;
   int burst_left   = 0;
   int gap_left     = 0;
   int hold_cnt     = 0;
   int pat_left     = 0;
   int stall_style  = 0;
   int pat_phase    = 0;
   bit long_hold_arm   = 0;
   bit long_hold_taken = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic queue_frame(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic status);
      logic [23:0]     grb;
      logic [1:0]      pair;
      rsp_payload_type b;
      grb = {green, red, blue};
      for (int k = 0; k < FRAME_LEN; k++) begin
         if (k < LEAD_ZEROS) begin
            b.line_byte = 8'h00;
         end else begin
            pair = grb[23 - 2 * (k - LEAD_ZEROS) -: 2];
            b.line_byte = {1'b1, pair[1], 2'b00, 1'b1, pair[0], 2'b00};
         end
         b.frame_end = (k == FRAME_LEN - 1);
         b.status    = status;
         line_bytes_due.push_back(b);
      end
   endtask

   task automatic predict_line_bytes(input req_payload_type p);
      case (p.command)
         CMD_SET_COLOR: begin
            queue_frame(p.red, p.green, p.blue, 1'b0);
         end
         CMD_TICK: begin
            if (breath_now == BREATH_RISE) begin
               if (blue_lvl == fade_top_q) breath_now = BREATH_FALL;
               blue_lvl = blue_lvl + 8'd1;
               queue_frame(8'd0, 8'd0, blue_lvl, 1'b0);
            end else if (breath_now == BREATH_FALL) begin
               if (blue_lvl < fade_floor_q) breath_now = BREATH_RISE;
               blue_lvl = blue_lvl - 8'd1;
               queue_frame(8'd0, 8'd0, blue_lvl, 1'b0);
            end
         end
         CMD_MODE: begin
            if (p.mode_sel == MODE_OFF) begin
               queue_frame(8'd0, 8'd0, 8'd0, 1'b0);
               breath_now = BREATH_OFF;
            end else if (p.mode_sel == MODE_BREATH) begin
               queue_frame(8'd0, 8'd0, 8'd0, 1'b0);
               breath_now = BREATH_RISE;
               blue_lvl   = 8'd0;
            end else begin
               queue_frame(8'd0, 8'd0, 8'd0, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endtask

   // request driver: bursts and gaps, hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_line_bytes(req_if.payload);
            void'(pending_reqs.pop_front());
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_if.valid   <= 1'b1;
               req_if.payload <= pending_reqs[0];
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 8);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // line byte receiver: own stall pattern plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_cnt     <= 0;
         pat_left     <= 0;
      end else if (long_hold_arm && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_cnt        <= LONG_HOLD;
         rsp_if.ready    <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt     <= hold_cnt - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            pat_left    <= $urandom_range(50, 300);
         end else begin
            pat_left <= pat_left - 1;
         end
         pat_phase <= (pat_phase == 6) ? 0 : pat_phase + 1;
         case (stall_style)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 2) != 0);
            default: rsp_if.ready <= (pat_phase < 4);
         endcase
      end
   end

   // line byte checker
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (line_bytes_due.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected line byte: byte=%02h end=%0b status=%0b",
                        rsp_if.payload.line_byte, rsp_if.payload.frame_end,
                        rsp_if.payload.status);
         end else begin
            want = line_bytes_due.pop_front();
            if (rsp_if.payload.line_byte !== want.line_byte ||
                rsp_if.payload.frame_end !== want.frame_end ||
                rsp_if.payload.status !== want.status) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("line byte mismatch: exp %02h/%0b/%0b, got %02h/%0b/%0b",
                           want.line_byte, want.frame_end, want.status,
                           rsp_if.payload.line_byte, rsp_if.payload.frame_end,
                           rsp_if.payload.status);
            end
         end
      end
   end

   task automatic push_req(input logic [1:0] cmd, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue,
                           input logic [7:0] mode);
      req_payload_type p;
      p.command  = cmd;
      p.red      = red;
      p.green    = green;
      p.blue     = blue;
      p.mode_sel = mode;
      @(negedge clock);
      pending_reqs.push_back(p);
   endtask

   task automatic push_noise_fields(input logic [1:0] cmd, input logic [7:0] mode);
      push_req(cmd, 8'($urandom), 8'($urandom), 8'($urandom), mode);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_if.valid || line_bytes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FADE_TOP) fade_top_q = val;
      else fade_floor_q = val;
   endtask

   task automatic push_random_phase(input int n_items);
      int done;
      int pick;
      int ticks;
      done = 0;
      while (done < n_items) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            push_noise_fields(CMD_MODE, MODE_BREATH);
            ticks = $urandom_range(3, 14);
            for (int t = 0; t < ticks; t++) begin
               if ($urandom_range(0, 7) == 0) push_noise_fields(CMD_SET_COLOR, 8'($urandom));
               else push_noise_fields(CMD_TICK, 8'($urandom));
            end
            done += ticks + 1;
            if ($urandom_range(0, 2) == 0) begin
               push_noise_fields(CMD_MODE, MODE_OFF);
               done++;
            end
         end else if (pick <= 7) begin
            push_noise_fields(CMD_SET_COLOR, 8'($urandom));
            done++;
         end else if (pick == 8) begin
            push_noise_fields(2'($urandom_range(0, 3)), 8'($urandom));
            done++;
         end else begin
            push_noise_fields(CMD_MODE, 8'($urandom));
            done++;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_FADE_TOP;
      csr_wr_data    = 8'd0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default registers: extremes of colour, every command, special cases
      push_req(CMD_SET_COLOR, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_SET_COLOR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_req(CMD_SET_COLOR, 8'h1B, 8'hE4, 8'h6C, 8'h00);
      push_req(CMD_SET_COLOR, 8'hAA, 8'h55, 8'h0F, 8'h00);
      push_req(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_req(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, 8'h02);
      push_req(CMD_MODE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, MODE_OFF);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, MODE_BREATH);
      for (int i = 0; i < 4; i++) push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_SET_COLOR, 8'h12, 8'h34, 8'h56, 8'h01);
      push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, 8'h80);
      push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, MODE_BREATH);
      push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, MODE_OFF);
      push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_req(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      wait_idle();

      // small top, floor of one: fast turnarounds
      write_csr(CSR_FADE_TOP, 8'd3);
      write_csr(CSR_FADE_FLOOR, 8'd1);
      push_random_phase(20);
      wait_idle();

      // top at zero, floor at max; long output hold fills the block
      write_csr(CSR_FADE_TOP, 8'd0);
      write_csr(CSR_FADE_FLOOR, 8'd255);
      @(negedge clock);
      long_hold_arm = 1'b1;
      push_random_phase(15);
      wait_idle();

      // floor below every level: falling wraps through zero
      write_csr(CSR_FADE_TOP, 8'd1);
      write_csr(CSR_FADE_FLOOR, 8'd0);
      push_req(CMD_MODE, 8'h00, 8'h00, 8'h00, MODE_BREATH);
      for (int i = 0; i < 6; i++) push_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
      push_random_phase(12);
      wait_idle();

      write_csr(CSR_FADE_TOP, 8'd254);
      write_csr(CSR_FADE_FLOOR, 8'd255);
      push_random_phase(8);
      wait_idle();

      for (int ph = 0; ph < 2; ph++) begin
         write_csr(CSR_FADE_TOP, 8'($urandom_range(0, 12)));
         write_csr(CSR_FADE_FLOOR, 8'($urandom_range(1, 12)));
         push_random_phase(10);
         wait_idle();
      end

      if (mismatch_cnt == 0 && line_bytes_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
